// File: hw/rtl/gqtl_pkg.sv
// Shared constants, types and helpers for the glyph quad text layout block.
`default_nettype none

package gqtl_pkg;

  localparam int GLYPH_COUNT = 256;
  localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
  localparam int MAX_QUADS   = 65536;
  localparam int QCNT_W      = $clog2(MAX_QUADS);
  localparam int VBASE_W     = 18;

  localparam int CODE_W = 21;
  localparam int ATLAS_W = 16;
  localparam int TEXV_W = 17;
  localparam int SCALE_W = 32;
  localparam int MAXW_W = 31;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Multiplier operand, partial product and pen-sum widths.
  localparam int OPND_W = 34;
  localparam int PROD_W = OPND_W + 17;
  localparam int WIDE_W = PROD_W + 1;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PLACE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [CODE_W-1:0] CH_SPACE   = CODE_W'(32);
  localparam logic [CODE_W-1:0] CH_NEWLINE = CODE_W'(10);

  localparam logic [0:0] REG_SCALE      = 1'd0;
  localparam logic [0:0] REG_WRAP_LIMIT = 1'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;
  localparam logic [TEXV_W-1:0]  Q_ONE       = 17'h1_0000;

  typedef struct packed {
    logic [ATLAS_W-1:0] x0;
    logic [ATLAS_W-1:0] x1;
    logic [ATLAS_W-1:0] y0;
    logic [ATLAS_W-1:0] y1;
    logic signed [31:0] offx;
    logic signed [31:0] offy;
    logic signed [31:0] adv;
  } glyph_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-32:0] top;
    top = v[WIDE_W-1:31];
    if (top == '0 || top == '1) begin
      return v[31:0];
    end
    return v[WIDE_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gqtl_glyph_mem.sv
// Glyph metric table: one write port and one registered read port on one address.
`default_nettype none

module gqtl_glyph_mem import gqtl_pkg::*; (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic                   rd_en,
  input  logic [GLYPH_IDX_W-1:0] addr,
  input  glyph_t                 wr_data,
  output glyph_t                 rd_data
);

  glyph_t mem [GLYPH_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gqtl_qmul.sv
// Two-stage Q16.16 scale multiply: floor(opnd * scale / 65536), split in halves.
`default_nettype none

module gqtl_qmul import gqtl_pkg::*; (
  input  logic                     clk,
  input  logic                     prod_en,
  input  logic                     sum_en,
  input  logic signed [OPND_W-1:0] opnd,
  input  logic [SCALE_W-1:0]       scale,
  output logic signed [PROD_W-1:0] q
);

  logic signed [PROD_W-1:0] prod_hi_next;
  logic signed [PROD_W-1:0] prod_lo_next;
  logic signed [PROD_W-1:0] prod_hi;
  logic signed [PROD_W-1:0] prod_lo;

  assign prod_hi_next = opnd * $signed({1'b0, scale[31:16]});
  assign prod_lo_next = opnd * $signed({1'b0, scale[15:0]});

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod_hi <= prod_hi_next;
      prod_lo <= prod_lo_next;
    end
    // Arithmetic shift floors the low half toward minus infinity.
    if (sum_en) begin
      q <= prod_hi + (prod_lo >>> 16);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/glyph_quad_text_layout_top.sv
// Glyph quad text layout: glyph table, scaling pipeline, pen and word-wrap state.
//
// Input channel (in_valid/in_ready) takes one transaction per item: op selects
// load glyph entry, place character or start new text. Output channel
// (out_valid/out_ready) delivers one quad per placed character that is drawn;
// loads, starts, newlines, wrapping spaces and codes outside the glyph table
// deliver nothing. Write scale/wrap limit over APB only while idle; not enforced.
//
// Each item passes the glyph table read, split multiply, partial-product sum,
// then pen add into the output register. One item is accepted every cycle
// while in_ready is high; the pen add and saturate is the only step that
// depends on the previous item. Each stage advances on its own, so an item
// that gives no result moves on while a quad waits in the output register,
// and in_ready drops only once every stage behind it is full.
// Reset clears the pen, quad count, wrap flag and stage valids and loads the
// default scale of 1.0 and wrap limit of 0; glyph entries are undefined until
// loaded. No clearing pass is needed.
`default_nettype none

module glyph_quad_text_layout_top import gqtl_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic [CODE_W-1:0]         code,
  input  logic [ATLAS_W-1:0]        atlas_left,
  input  logic [ATLAS_W-1:0]        atlas_right,
  input  logic [ATLAS_W-1:0]        atlas_top,
  input  logic [ATLAS_W-1:0]        atlas_bottom,
  input  logic signed [31:0]        offset_x,
  input  logic signed [31:0]        offset_y,
  input  logic signed [31:0]        advance_x,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        left_x,
  output logic signed [31:0]        bottom_y,
  output logic signed [31:0]        quad_width,
  output logic signed [31:0]        quad_height,
  output logic [ATLAS_W-1:0]        tex_u_left,
  output logic [ATLAS_W-1:0]        tex_u_right,
  output logic [TEXV_W-1:0]         tex_v_lower,
  output logic [TEXV_W-1:0]         tex_v_upper,
  output logic [VBASE_W-1:0]        vertex_base,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  typedef struct packed {
    logic [1:0]         op;
    logic               hit;
    logic               space;
    logic               newline;
    logic [ATLAS_W-1:0] x0;
    logic [ATLAS_W-1:0] x1;
    logic [ATLAS_W-1:0] y0;
    logic [ATLAS_W-1:0] y1;
  } stage_t;

  // Configuration
  logic [SCALE_W-1:0] scale;
  logic [MAXW_W-1:0]  wrap_limit;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale      <= SCALE_RESET;
      wrap_limit <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SCALE:      scale      <= pwdata;
        REG_WRAP_LIMIT: wrap_limit <= pwdata[MAXW_W-1:0];
        default:        scale      <= scale;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SCALE:      prdata = scale;
      REG_WRAP_LIMIT: prdata = {1'b0, wrap_limit};
      default:        prdata = '0;
    endcase
  end

  // Stage handshake
  logic v1, v2, v3;
  logic go1, go2, go3;
  logic ready1, ready2, ready3;
  logic accept;
  logic emit;

  assign ready3   = !v3 || go3;
  assign go2      = v2 && ready3;
  assign ready2   = !v2 || go2;
  assign go1      = v1 && ready2;
  assign ready1   = !v1 || go1;
  assign in_ready = ready1;
  assign accept   = in_valid && in_ready;
  assign go3      = v3 && (!emit || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (go1) begin
        v1 <= 1'b0;
      end
      if (go1) begin
        v2 <= 1'b1;
      end else if (go2) begin
        v2 <= 1'b0;
      end
      if (go2) begin
        v3 <= 1'b1;
      end else if (go3) begin
        v3 <= 1'b0;
      end
    end
  end

  // Stage 1: glyph table read
  logic                   in_hit;
  logic                   load_wr;
  glyph_t                 load_data;
  glyph_t                 rd;
  logic [ATLAS_W-1:0]     nl_y1;
  logic [ATLAS_W-1:0]     nl_y1_s1;
  logic [1:0]             op1;
  logic                   hit1;
  logic                   space1;
  logic                   newline1;

  assign in_hit  = code < CODE_W'(GLYPH_COUNT);
  assign load_wr = accept && op == OP_LOAD && in_hit;

  assign load_data = '{x0: atlas_left, x1: atlas_right, y0: atlas_top, y1: atlas_bottom,
                       offx: offset_x, offy: offset_y, adv: advance_x};

  gqtl_glyph_mem u_glyph_mem (
    .clk     (clk),
    .wr_en   (load_wr),
    .rd_en   (accept),
    .addr    (code[GLYPH_IDX_W-1:0]),
    .wr_data (load_data),
    .rd_data (rd)
  );

  // Keep a copy of the newline glyph bottom for wrapping spaces.
  always_ff @(posedge clk) begin
    if (load_wr && code == CH_NEWLINE) begin
      nl_y1 <= atlas_bottom;
    end
    if (accept) begin
      op1      <= op;
      hit1     <= in_hit;
      space1   <= code == CH_SPACE;
      newline1 <= code == CH_NEWLINE;
      nl_y1_s1 <= nl_y1;
    end
  end

  // Multiplier operands
  logic signed [OPND_W-1:0] opnd_uh;
  logic signed [OPND_W-1:0] opnd_uw;
  logic signed [OPND_W-1:0] opnd_offx;
  logic signed [OPND_W-1:0] opnd_drop;
  logic signed [OPND_W-1:0] opnd_adv;
  logic signed [OPND_W-1:0] opnd_nl;

  assign opnd_uh   = OPND_W'($signed({1'b0, rd.y1})) - OPND_W'($signed({1'b0, rd.y0}));
  assign opnd_uw   = OPND_W'($signed({1'b0, rd.x1})) - OPND_W'($signed({1'b0, rd.x0}));
  assign opnd_offx = OPND_W'(rd.offx);
  assign opnd_drop = opnd_uh - OPND_W'(rd.offy);
  assign opnd_adv  = OPND_W'(rd.adv);
  assign opnd_nl   = OPND_W'($signed({1'b0, nl_y1_s1}));

  logic signed [PROD_W-1:0] q_uh, q_uw, q_offx, q_drop, q_adv, q_nl;

  gqtl_qmul u_mul_uh (.clk(clk), .prod_en(go1), .sum_en(go2), .opnd(opnd_uh),
                      .scale(scale), .q(q_uh));
  gqtl_qmul u_mul_uw (.clk(clk), .prod_en(go1), .sum_en(go2), .opnd(opnd_uw),
                      .scale(scale), .q(q_uw));
  gqtl_qmul u_mul_offx (.clk(clk), .prod_en(go1), .sum_en(go2), .opnd(opnd_offx),
                        .scale(scale), .q(q_offx));
  gqtl_qmul u_mul_drop (.clk(clk), .prod_en(go1), .sum_en(go2), .opnd(opnd_drop),
                        .scale(scale), .q(q_drop));
  gqtl_qmul u_mul_adv (.clk(clk), .prod_en(go1), .sum_en(go2), .opnd(opnd_adv),
                       .scale(scale), .q(q_adv));
  gqtl_qmul u_mul_nl (.clk(clk), .prod_en(go1), .sum_en(go2), .opnd(opnd_nl),
                      .scale(scale), .q(q_nl));

  // Stages 2 and 3: carry control and atlas coordinates alongside the products
  stage_t st2, st3;

  always_ff @(posedge clk) begin
    if (go1) begin
      st2 <= '{op: op1, hit: hit1, space: space1, newline: newline1,
               x0: rd.x0, x1: rd.x1, y0: rd.y0, y1: rd.y1};
    end
    if (go2) begin
      st3 <= st2;
    end
  end

  // Stage 3: pen, wrap and quad count
  logic signed [31:0] pen_x, pen_y;
  logic [QCNT_W-1:0]  quad_count;
  logic               wrap_pending;
  logic               wrap_now;
  logic               place;
  logic               space_wrap;
  logic               newline_now;
  logic signed [31:0] adv_sat;
  logic signed [31:0] pen_x_adv;
  logic signed [31:0] y_space;
  logic signed [31:0] y_newline;
  logic signed [31:0] x_quad;
  logic signed [31:0] y_quad;

  assign wrap_now = wrap_pending ||
                    (wrap_limit != '0 &&
                     $signed({pen_x[31], pen_x}) > $signed({2'b00, wrap_limit}));
  assign place       = v3 && st3.op == OP_PLACE && st3.hit;
  assign space_wrap  = place && st3.space && wrap_now;
  assign newline_now = place && st3.newline;
  assign emit        = place && !space_wrap && !st3.newline;

  assign adv_sat   = sat32(WIDE_W'(q_adv));
  assign pen_x_adv = sat32(WIDE_W'(pen_x) + WIDE_W'(adv_sat));
  assign y_space   = sat32(WIDE_W'(pen_y) - WIDE_W'(q_nl));
  assign y_newline = sat32(WIDE_W'(pen_y) - WIDE_W'(q_uh));
  assign x_quad    = sat32(WIDE_W'(pen_x) + WIDE_W'(q_offx));
  assign y_quad    = sat32(WIDE_W'(pen_y) - WIDE_W'(q_drop));

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x        <= '0;
      pen_y        <= '0;
      quad_count   <= '0;
      wrap_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // Load a new quad or hold the waiting one until it is taken.
      out_valid <= (go3 && emit) || (out_valid && !out_ready);
      if (go3) begin
        if (st3.op == OP_START) begin
          pen_x        <= '0;
          pen_y        <= '0;
          quad_count   <= '0;
          wrap_pending <= 1'b0;
        end else if (space_wrap) begin
          pen_x        <= '0;
          pen_y        <= y_space;
          wrap_pending <= 1'b0;
        end else if (newline_now) begin
          pen_x        <= '0;
          pen_y        <= y_newline;
          wrap_pending <= 1'b0;
        end else if (emit) begin
          pen_x        <= pen_x_adv;
          quad_count   <= quad_count + 1'b1;
          wrap_pending <= wrap_now;
        end
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (go3 && emit) begin
      left_x      <= x_quad;
      bottom_y    <= y_quad;
      quad_width  <= sat32(WIDE_W'(q_uw));
      quad_height <= sat32(WIDE_W'(q_uh));
      tex_u_left  <= st3.x0;
      tex_u_right <= st3.x1;
      tex_v_lower <= Q_ONE - {1'b0, st3.y1};
      tex_v_upper <= Q_ONE - {1'b0, st3.y0};
      vertex_base <= VBASE_W'({quad_count, 2'b00});
    end
  end

  // Assertions
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    go3 && emit |=> out_valid)
    else $error("placed quad did not reach the output register");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    go3 && emit |=> quad_count == $past(quad_count) + 1'b1)
    else $error("quad count did not advance on a drawn quad");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    go3 && st3.op == OP_START |=> pen_x == '0 && pen_y == '0 && quad_count == '0
                                  && !wrap_pending)
    else $error("start transaction did not clear layout state");

  a_silent_moves: assert property (@(posedge clk) disable iff (rst)
    v3 && !emit |-> go3)
    else $error("item without a result stalled in the last stage");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> in_ready)
    else $error("input not ready with an empty first stage");

endmodule

`default_nettype wire

// File: bench/gqtl_tb_pkg.sv
// Transaction types and the quad layout scoreboard for the glyph quad text layout bench.
package gqtl_tb_pkg;
  import gqtl_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [CODE_W-1:0]  code;
    logic [ATLAS_W-1:0] x0;
    logic [ATLAS_W-1:0] x1;
    logic [ATLAS_W-1:0] y0;
    logic [ATLAS_W-1:0] y1;
    logic signed [31:0] offx;
    logic signed [31:0] offy;
    logic signed [31:0] adv;
  } text_item_t;

  localparam int ITEM_W = $bits(text_item_t);

  typedef struct packed {
    logic signed [31:0] left_x;
    logic signed [31:0] bottom_y;
    logic signed [31:0] quad_width;
    logic signed [31:0] quad_height;
    logic [ATLAS_W-1:0] tex_u_left;
    logic [ATLAS_W-1:0] tex_u_right;
    logic [TEXV_W-1:0]  tex_v_lower;
    logic [TEXV_W-1:0]  tex_v_upper;
    logic [VBASE_W-1:0] vertex_base;
  } quad_t;

  class quad_scoreboard;
    glyph_t             glyphs [GLYPH_COUNT];
    logic signed [31:0] pen_x;
    logic signed [31:0] pen_y;
    logic [QCNT_W-1:0]  quad_count;
    bit                 wrap_armed;
    logic [SCALE_W-1:0] scale;
    logic [MAXW_W-1:0]  wrap_limit;
    quad_t              quads_due [$];
    int                 errors;

    function new();
      pen_x      = '0;
      pen_y      = '0;
      quad_count = '0;
      wrap_armed = 1'b0;
      scale      = SCALE_RESET;
      wrap_limit = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [PDATA_W-1:0] value);
      if (idx == REG_SCALE) begin
        scale = value[SCALE_W-1:0];
      end else if (idx == REG_WRAP_LIMIT) begin
        wrap_limit = value[MAXW_W-1:0];
      end
    endfunction

    // Exact product with scale, floored back to Q16.16.
    function logic signed [79:0] scaled(logic signed [79:0] a);
      logic signed [79:0] prod;
      prod = a * $signed({48'd0, scale});
      return prod >>> 16;
    endfunction

    function logic signed [31:0] clamp(logic signed [79:0] v);
      if (v > 80'sh7FFF_FFFF) begin
        return 32'sh7FFF_FFFF;
      end
      if (v < -80'sh8000_0000) begin
        return 32'sh8000_0000;
      end
      return v[31:0];
    endfunction

    function void advance_layout(text_item_t it);
      glyph_t             g;
      logic signed [79:0] uw;
      logic signed [79:0] uh;
      logic signed [79:0] step;
      quad_t              q;
      if (it.op == OP_START) begin
        pen_x      = '0;
        pen_y      = '0;
        quad_count = '0;
        wrap_armed = 1'b0;
        return;
      end
      if (it.code >= GLYPH_COUNT) begin
        return;
      end
      if (it.op == OP_LOAD) begin
        glyphs[it.code[GLYPH_IDX_W-1:0]] = '{it.x0, it.x1, it.y0, it.y1,
                                             it.offx, it.offy, it.adv};
        return;
      end
      if (it.op != OP_PLACE) begin
        return;
      end
      g  = glyphs[it.code[GLYPH_IDX_W-1:0]];
      uw = 80'(g.x1) - 80'(g.x0);
      uh = 80'(g.y1) - 80'(g.y0);
      if (wrap_limit != '0 && pen_x > $signed({1'b0, wrap_limit})) begin
        wrap_armed = 1'b1;
      end
      // Wrapping space drops down by the newline glyph's bottom coordinate.
      if (it.code == CH_SPACE && wrap_armed) begin
        pen_x      = '0;
        pen_y      = clamp(pen_y - scaled(80'(glyphs[CH_NEWLINE[GLYPH_IDX_W-1:0]].y1)));
        wrap_armed = 1'b0;
        return;
      end
      if (it.code == CH_NEWLINE) begin
        pen_x      = '0;
        pen_y      = clamp(pen_y - scaled(uh));
        wrap_armed = 1'b0;
        return;
      end
      q.left_x      = clamp(pen_x + scaled(g.offx));
      q.bottom_y    = clamp(pen_y - scaled(uh - g.offy));
      q.quad_width  = clamp(scaled(uw));
      q.quad_height = clamp(scaled(uh));
      q.tex_u_left  = g.x0;
      q.tex_u_right = g.x1;
      q.tex_v_lower = Q_ONE - TEXV_W'(g.y1);
      q.tex_v_upper = Q_ONE - TEXV_W'(g.y0);
      q.vertex_base = VBASE_W'({quad_count, 2'b00});
      step          = clamp(scaled(g.adv));
      pen_x         = clamp(pen_x + step);
      quad_count    = quad_count + 1'b1;
      quads_due     = {quads_due, q};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got, time stamp);
      if (want !== got) begin
        $display("%0t: %s expected %h actual %h", stamp, name, want, got);
        errors++;
      end
    endfunction

    function void check_quad(quad_t got, time stamp);
      quad_t want;
      if (quads_due.size() == 0) begin
        $display("%0t: quad expected none actual %h", stamp, got);
        errors++;
        return;
      end
      want = quads_due.pop_front();
      compare_field("left_x", want.left_x, got.left_x, stamp);
      compare_field("bottom_y", want.bottom_y, got.bottom_y, stamp);
      compare_field("quad_width", want.quad_width, got.quad_width, stamp);
      compare_field("quad_height", want.quad_height, got.quad_height, stamp);
      compare_field("tex_u_left", 32'(want.tex_u_left), 32'(got.tex_u_left), stamp);
      compare_field("tex_u_right", 32'(want.tex_u_right), 32'(got.tex_u_right), stamp);
      compare_field("tex_v_lower", 32'(want.tex_v_lower), 32'(got.tex_v_lower), stamp);
      compare_field("tex_v_upper", 32'(want.tex_v_upper), 32'(got.tex_v_upper), stamp);
      compare_field("vertex_base", 32'(want.vertex_base), 32'(got.vertex_base), stamp);
    endfunction

    function int outstanding();
      return quads_due.size();
    endfunction
  endclass

endpackage

// File: bench/tb_glyph_quad_text_layout_top.sv
// Bench for glyph_quad_text_layout_top: directed and random text checked against a layout scoreboard.
module tb_glyph_quad_text_layout_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gqtl_pkg::*;
  import gqtl_tb_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 68;
  localparam int PHASES         = 6;
  // Length of the closing back-to-back burst.
  localparam int LONG_RUN       = 24;

  localparam logic [CODE_W-1:0] CH_A   = CODE_W'(65);
  localparam logic [CODE_W-1:0] CH_B   = CODE_W'(66);
  localparam logic [CODE_W-1:0] CH_C   = CODE_W'(67);
  localparam logic [CODE_W-1:0] CH_NUL = CODE_W'(0);

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [1:0]          op           = OP_LOAD;
  logic [CODE_W-1:0]   code         = '0;
  logic [ATLAS_W-1:0]  atlas_left   = '0;
  logic [ATLAS_W-1:0]  atlas_right  = '0;
  logic [ATLAS_W-1:0]  atlas_top    = '0;
  logic [ATLAS_W-1:0]  atlas_bottom = '0;
  logic signed [31:0]  offset_x     = '0;
  logic signed [31:0]  offset_y     = '0;
  logic signed [31:0]  advance_x    = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic signed [31:0]  left_x;
  logic signed [31:0]  bottom_y;
  logic signed [31:0]  quad_width;
  logic signed [31:0]  quad_height;
  logic [ATLAS_W-1:0]  tex_u_left;
  logic [ATLAS_W-1:0]  tex_u_right;
  logic [TEXV_W-1:0]   tex_v_lower;
  logic [TEXV_W-1:0]   tex_v_upper;
  logic [VBASE_W-1:0]  vertex_base;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [PADDR_W-1:0]  paddr        = '0;
  logic [PDATA_W-1:0]  pwdata       = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  quad_scoreboard sb = new();
  bit             loaded [GLYPH_COUNT];
  bit             sender_idles = 1'b0;
  bit             sink_stalls  = 1'b0;
  int             ready_hold   = 0;
  int             idle_cycles  = 0;

  glyph_quad_text_layout_top dut (.*);

  always #4 clk = ~clk;

  // Receiver: short ready bursts, mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!sink_stalls) begin
      out_ready <= 1'b1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin : monitor
    quad_t      got;
    text_item_t seen;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{left_x, bottom_y, quad_width, quad_height, tex_u_left, tex_u_right,
                tex_v_lower, tex_v_upper, vertex_base};
        sb.check_quad(got, $time);
      end
      if (in_valid && in_ready) begin
        seen = '{op, code, atlas_left, atlas_right, atlas_top, atlas_bottom,
                 offset_x, offset_y, advance_x};
        sb.advance_layout(seen);
      end
      idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    @(negedge rst);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic text_item_t random_fields();
    return text_item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
  endfunction

  function automatic text_item_t load_item(input logic [CODE_W-1:0] c,
                                           input logic [ATLAS_W-1:0] x0, x1, y0, y1,
                                           input logic signed [31:0] offx, offy, adv);
    return '{OP_LOAD, c, x0, x1, y0, y1, offx, offy, adv};
  endfunction

  function automatic text_item_t place_item(input logic [CODE_W-1:0] c);
    text_item_t it;
    it      = random_fields();
    it.op   = OP_PLACE;
    it.code = c;
    return it;
  endfunction

  function automatic text_item_t random_load(input logic [CODE_W-1:0] c);
    text_item_t it;
    it      = random_fields();
    it.op   = OP_LOAD;
    it.code = c;
    // Keep most metrics text-like so the pen actually crosses the wrap width.
    if ($urandom_range(0, 9) != 0) begin
      it.offx = $signed($urandom_range(0, 8 << 16)) - (2 << 16);
      it.offy = $signed($urandom_range(0, 16 << 16)) - (4 << 16);
      it.adv  = $signed($urandom_range(1 << 16, 12 << 16));
    end
    return it;
  endfunction

  function automatic text_item_t next_text_item();
    text_item_t        it;
    int                r;
    logic [CODE_W-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      c  = ($urandom_range(0, 3) == 0) ? CODE_W'($urandom_range(0, GLYPH_COUNT - 1))
                                       : CODE_W'($urandom_range(65, 90));
      it = random_load(c);
    end else if (r < 12) begin
      it    = random_fields();
      it.op = OP_START;
    end else if (r < 18) begin
      it = random_fields();
      if ($urandom_range(0, 1) == 0) begin
        it.op = OP_UNUSED;
      end else begin
        it.op   = ($urandom_range(0, 1) == 0) ? OP_LOAD : OP_PLACE;
        it.code = CODE_W'($urandom_range(GLYPH_COUNT, 2 ** CODE_W - 1));
      end
    end else if (r < 40) begin
      it = place_item(CH_SPACE);
    end else if (r < 48) begin
      it = place_item(CH_NEWLINE);
    end else begin
      // Only place glyphs that hold a loaded entry.
      do begin
        c = CODE_W'($urandom_range(0, GLYPH_COUNT - 1));
      end while (!loaded[c[GLYPH_IDX_W-1:0]]);
      it = place_item(c);
    end
    return it;
  endfunction

  task automatic send_item(input text_item_t it);
    int gap;
    int r;
    gap = 0;
    if (sender_idles) begin
      r = $urandom_range(0, 99);
      if (r >= 55) begin
        gap = (r >= 94) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= it.op;
    code         <= it.code;
    atlas_left   <= it.x0;
    atlas_right  <= it.x1;
    atlas_top    <= it.y0;
    atlas_bottom <= it.y1;
    offset_x     <= it.offx;
    offset_y     <= it.offy;
    advance_x    <= it.adv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.op == OP_LOAD && it.code < GLYPH_COUNT) begin
      loaded[it.code[GLYPH_IDX_W-1:0]] = 1'b1;
    end
  endtask

  // Hold the sender until every quad is out, then let the pipeline empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  initial begin
    logic [SCALE_W-1:0] scales [PHASES];
    logic [PDATA_W-1:0] widths [PHASES];
    text_item_t         it;
    scales = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000,
               32'h0000_8000, 32'h0002_8000, 32'h0001_0000};
    widths = '{32'h7FFF_FFFF, 32'h0000_0001, 32'h0028_0000,
               32'h803C_0000, 32'h0000_0000, 32'h0000_0000};
    scales[PHASES-1] = $urandom_range(32'h0000_4000, 32'h0004_0000);
    widths[PHASES-1] = $urandom;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed text at reset settings: extremes, ignored codes, newline, start.
    send_item(load_item(CH_NEWLINE, 16'd0, 16'd0, 16'd100, 16'd3000, 32'sd0, 32'sd0, 32'sd0));
    send_item(load_item(CH_SPACE, 16'd10, 16'd400, 16'd50, 16'd1200,
                        32'sd0, 32'sd0, 32'sh0005_0000));
    send_item(load_item(CH_A, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                        32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send_item(load_item(CH_B, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_item(load_item(CH_C, 16'd1200, 16'd2400, 16'd300, 16'd4000,
                        32'sh0002_0000, -32'sh0000_8000, 32'sh0006_0000));
    send_item(load_item(CH_NUL, 16'd5, 16'd9, 16'd7, 16'd11,
                        -32'sh0001_0000, 32'sh0001_0000, 32'sh0000_8000));
    send_item(load_item(CODE_W'(2 ** CODE_W - 1), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        -32'sd1, -32'sd1, -32'sd1));
    send_item(load_item(CODE_W'(GLYPH_COUNT), 16'd1, 16'd2, 16'd3, 16'd4,
                        32'sd5, 32'sd6, 32'sd7));
    send_item(place_item(CH_C));
    send_item(place_item(CH_A));
    send_item(place_item(CH_A));
    send_item(place_item(CH_B));
    send_item(place_item(CH_NEWLINE));
    send_item(place_item(CH_SPACE));
    send_item(place_item(CH_NUL));
    send_item(place_item(CODE_W'(2 ** CODE_W - 1)));
    it    = place_item(CH_C);
    it.op = OP_UNUSED;
    send_item(it);
    it    = random_fields();
    it.op = OP_START;
    send_item(it);
    send_item(place_item(CH_B));

    // Tiny wrap width: the next space after any advance starts a new line.
    wait_idle();
    write_reg(REG_WRAP_LIMIT, 32'd1);
    send_item(place_item(CH_C));
    send_item(place_item(CH_SPACE));
    send_item(place_item(CH_C));
    send_item(place_item(CH_NEWLINE));
    send_item(place_item(CH_SPACE));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(REG_SCALE, scales[p]);
      write_reg(REG_WRAP_LIMIT, widths[p]);
      sender_idles = (p % 3 != 1);
      sink_stalls  = (p % 3 != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 49) == 0) begin
          wait_idle();
        end
        send_item(next_text_item());
      end
    end

    // Back-to-back burst with the receiver always ready.
    wait_idle();
    write_reg(REG_SCALE, SCALE_RESET);
    write_reg(REG_WRAP_LIMIT, 32'd0);
    sender_idles = 1'b0;
    sink_stalls  = 1'b0;
    it    = random_fields();
    it.op = OP_START;
    send_item(it);
    for (int n = 0; n < LONG_RUN; n++) begin
      send_item(place_item(CH_C));
    end

    wait_idle();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
